>>> design/nss_pkg.sv
// Shared types and constants for the NFA subset step core.
// Holds the request and result structs and the operation codes.
// Used by nss_engine and nfa_subset_step_core.
package nss_pkg;

	// Field widths fixed by the request and result formats.
	localparam int MASK_W  = 32;
	localparam int INDEX_W = 5;
	localparam int CLASS_W = 6;
	localparam int TOKEN_W = 8;

	// Operation codes carried by a request.
	typedef enum logic [1:0] {
		OP_WR_TRANS  = 2'd0,
		OP_WR_ACCEPT = 2'd1,
		OP_START     = 2'd2,
		OP_STEP      = 2'd3
	} op_t;

	// One request.
	typedef struct packed {
		op_t                 opcode;
		logic [INDEX_W-1:0]  state_index;
		logic [CLASS_W-1:0]  symbol_class;
		logic [MASK_W-1:0]   target_mask;
		logic [TOKEN_W-1:0]  accept_value;
	} req_t;

	// One result.
	typedef struct packed {
		logic [MASK_W-1:0]   active_set;
		logic [TOKEN_W-1:0]  token_type;
		logic                set_empty;
	} res_t;

endpackage

>>> design/nfa_subset_step_core.sv
// NFA subset step core, top level: request intake and result register.
// Each request yields one result: the active state set after the operation, the smallest
// nonzero accept type among its states, and an empty flag. The set is held in flip-flops;
// the transition table (NUM_STATES x NUM_CLASSES masks) and the accept table sit in
// single-port memories with registered read data, and both are undefined until written.
// Requests are handled one at a time, and the single read port of the transition memory sets
// the pace: a step reads one word per active state, the epsilon closure reads one word per
// state it reaches (each state is expanded once, so epsilon loops end), and a final scan
// reads one accept type per active state. When epsilon edges form a chain, the closure waits
// for each newly found state until the read that found it returns. A table write only runs
// the accept scan. After a result is handed to the output register the engine returns to
// idle, and only then is the next request taken. A new request is taken while the previous
// result still waits in the output register. Mask bits at or above NUM_STATES are dropped.
// Depends on nss_pkg and nss_engine.
module nfa_subset_step_core #(
	parameter int NUM_STATES  = 32,
	parameter int NUM_CLASSES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  nss_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output nss_pkg::res_t res
);
	import nss_pkg::*;

	logic eng_idle;
	logic eng_done;
	logic eng_take;
	logic start;
	res_t eng_res;
	logic res_valid_q;
	res_t res_q;

	// A request is taken whenever the engine is idle.
	assign req_stall = !eng_idle;
	assign start     = req_valid && !req_stall;

	nss_engine #(
		.NUM_STATES  (NUM_STATES),
		.NUM_CLASSES (NUM_CLASSES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.idle   (eng_idle),
		.done   (eng_done),
		.take   (eng_take),
		.res    (eng_res)
	);

	// Output register: loads a finished result when it is empty or being drained.
	assign eng_take = eng_done && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (eng_take) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_take) begin
			res_q <= eng_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> design/nss_engine.sv
// Sequencer and table memories of the NFA subset step core.
// Walks the active set through the transition and accept memories.
// Depends on nss_pkg.
module nss_engine #(
	parameter int NUM_STATES  = 32,
	parameter int NUM_CLASSES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  nss_pkg::req_t req,
	output logic          idle,
	output logic          done,
	input  logic          take,
	output nss_pkg::res_t res
);
	import nss_pkg::*;

	localparam int NS = NUM_STATES;
	localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOVE,
		S_CLOS,
		S_TOKEN,
		S_DONE
	} state_t;

	// Lowest set bit of a state mask.
	function automatic logic [SW-1:0] first_set(input logic [NS-1:0] v);
		logic [SW-1:0] r;
		r = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (v[i]) r = SW'(i);
		end
		return r;
	endfunction

	// Table memories; contents are undefined until written.
	logic [NS-1:0]      trans_mem [NUM_STATES][NUM_CLASSES];
	logic [TOKEN_W-1:0] acc_mem   [NUM_STATES];

	state_t             state_q;
	logic [NS-1:0]      set_q;
	logic [NS-1:0]      pend_q;
	logic [NS-1:0]      move_q;
	logic [TOKEN_W-1:0] best_q;
	logic [CW-1:0]      cls_q;
	logic               rd_vld_s1;
	logic [NS-1:0]      trans_rd_s1;
	logic [TOKEN_W-1:0] acc_rd_s1;

	logic               st_ok;
	logic               cls_ok;
	logic [SW-1:0]      wr_st;
	logic [CW-1:0]      wr_cls;
	logic               wr_trans;
	logic               wr_accept;
	logic               issue;
	logic [SW-1:0]      pick;
	logic [NS-1:0]      pick_oh;
	logic [CW-1:0]      rd_cls;
	logic               scan_end;
	logic [NS-1:0]      pend_left;

	// Request decode: range checks and table addresses.
	assign st_ok     = 32'(req.state_index) < 32'(NUM_STATES);
	assign cls_ok    = 32'(req.symbol_class) < 32'(NUM_CLASSES);
	assign wr_st     = SW'(req.state_index);
	assign wr_cls    = CW'(req.symbol_class);
	assign wr_trans  = (state_q == S_IDLE) && start && (req.opcode == OP_WR_TRANS)
			&& st_ok && cls_ok;
	assign wr_accept = (state_q == S_IDLE) && start && (req.opcode == OP_WR_ACCEPT)
			&& st_ok;

	// One table read per cycle for the lowest pending state.
	assign issue     = ((state_q == S_MOVE) || (state_q == S_CLOS) || (state_q == S_TOKEN))
			&& (pend_q != '0);
	assign pick      = first_set(pend_q);
	assign pick_oh   = NS'(1) << pick;
	assign rd_cls    = (state_q == S_MOVE) ? cls_q : '0;
	assign pend_left = pend_q & ~pick_oh;
	// A phase ends once nothing is pending and no read is in flight.
	assign scan_end  = (pend_q == '0) && !rd_vld_s1;

	// Transition memory: one write or one read per cycle, registered read data.
	always_ff @(posedge clk) begin
		if (wr_trans) begin
			trans_mem[wr_st][wr_cls] <= NS'(req.target_mask);
		end
		if (issue) begin
			trans_rd_s1 <= trans_mem[pick][rd_cls];
		end
	end

	// Accept memory: one write or one read per cycle, registered read data.
	always_ff @(posedge clk) begin
		if (wr_accept) begin
			acc_mem[wr_st] <= req.accept_value;
		end
		if (issue) begin
			acc_rd_s1 <= acc_mem[pick];
		end
	end

	// Sequencer. Writes and reads never overlap: a write is taken only in idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			set_q     <= '0;
			pend_q    <= '0;
			move_q    <= '0;
			best_q    <= '0;
			cls_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						unique case (req.opcode) inside
							OP_WR_TRANS, OP_WR_ACCEPT: begin
								pend_q  <= set_q;
								best_q  <= '0;
								state_q <= S_TOKEN;
							end
							OP_START: begin
								set_q   <= NS'(req.target_mask);
								pend_q  <= NS'(req.target_mask);
								state_q <= S_CLOS;
							end
							OP_STEP: begin
								cls_q   <= wr_cls;
								move_q  <= '0;
								pend_q  <= cls_ok ? set_q : '0;
								state_q <= S_MOVE;
							end
						endcase
					end
				end
				// Move: OR the targets of every active state on the class.
				S_MOVE: begin
					if (scan_end) begin
						set_q   <= move_q;
						pend_q  <= move_q;
						state_q <= S_CLOS;
					end else begin
						pend_q <= pend_left;
						if (rd_vld_s1) move_q <= move_q | trans_rd_s1;
					end
				end
				// Closure: expand each reached state once on its epsilon word.
				S_CLOS: begin
					if (scan_end) begin
						pend_q  <= set_q;
						best_q  <= '0;
						state_q <= S_TOKEN;
					end else if (rd_vld_s1) begin
						set_q  <= set_q | trans_rd_s1;
						pend_q <= pend_left | (trans_rd_s1 & ~set_q);
					end else begin
						pend_q <= pend_left;
					end
				end
				// Token: smallest nonzero accept type over the active set.
				S_TOKEN: begin
					if (scan_end) begin
						state_q <= S_DONE;
					end else begin
						pend_q <= pend_left;
						if (rd_vld_s1 && (acc_rd_s1 != '0)
								&& ((best_q == '0) || (acc_rd_s1 < best_q))) begin
							best_q <= acc_rd_s1;
						end
					end
				end
				S_DONE: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result and status toward the top level.
	assign idle           = (state_q == S_IDLE);
	assign done           = (state_q == S_DONE);
	assign res.active_set = MASK_W'(set_q);
	assign res.token_type = best_q;
	assign res.set_empty  = (set_q == '0);

	// The active set only changes while an operation is running.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !start) |=> $stable(set_q))
		else $error("active set changed while idle");

	// The closure only adds states.
	a_clos_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOS) |=> ((set_q & $past(set_q)) == $past(set_q)))
		else $error("closure dropped a state");

	// States waiting for expansion or lookup are always active.
	a_pend_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOS || state_q == S_TOKEN) |-> ((pend_q & ~set_q) == '0))
		else $error("pending state outside active set");

	// The token scan leaves the set untouched.
	a_token_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOKEN) |=> $stable(set_q))
		else $error("active set changed during token scan");

	// A result is offered only after all reads have returned.
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !rd_vld_s1)
		else $error("result offered with a read in flight");

endmodule

>>> tb/sv/tb_nfa_subset_step_core.sv
`timescale 1ns / 1ps
// Testbench for nfa_subset_step_core: a table fill, directed requests and random sequences,
// checked against a bit-set prediction of the NFA held in a small scoreboard class.
// Depends on nss_pkg and the design files of the core.
module tb_nfa_subset_step_core;
	import nss_pkg::*;

	localparam int N_STATES     = 32;
	localparam int N_CLASSES    = 64;
	localparam int RANDOM_ITEMS = 1000;
	localparam int DRAIN_CYCLES = 3 * N_STATES + 30;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam logic [CLASS_W-1:0] EPS_CLASS = '0;

	// Predicted NFA state plus the queue of results still to come.
	class nfa_set_tracker;
		logic [MASK_W-1:0]  next_states [N_STATES][N_CLASSES];
		logic [TOKEN_W-1:0] token_of [N_STATES];
		logic [MASK_W-1:0]  rows_written [N_CLASSES];
		logic [MASK_W-1:0]  tokens_written;
		logic [MASK_W-1:0]  active;
		res_t               expected_sets [$];
		int                 errors;

		function new();
			active = '0;
			tokens_written = '0;
			errors = 0;
			foreach (rows_written[c]) rows_written[c] = '0;
			foreach (next_states[s, c]) next_states[s][c] = '0;
			foreach (token_of[s]) token_of[s] = '0;
		endfunction

		// Epsilon closure, iterated until the set stops growing.
		function logic [MASK_W-1:0] closure(logic [MASK_W-1:0] set);
			logic [MASK_W-1:0] prev;
			do begin
				prev = set;
				for (int s = 0; s < N_STATES; s++)
					if (set[s]) set |= next_states[s][EPS_CLASS];
			end while (set != prev);
			return set;
		endfunction

		function logic [MASK_W-1:0] move_on(logic [MASK_W-1:0] set, logic [CLASS_W-1:0] cls);
			logic [MASK_W-1:0] targets;
			targets = '0;
			for (int s = 0; s < N_STATES; s++)
				if (set[s]) targets |= next_states[s][cls];
			return targets;
		endfunction

		function logic [TOKEN_W-1:0] lowest_token(logic [MASK_W-1:0] set);
			logic [TOKEN_W-1:0] best;
			best = '0;
			for (int s = 0; s < N_STATES; s++)
				if (set[s] && token_of[s] != 0 && (best == 0 || token_of[s] < best))
					best = token_of[s];
			return best;
		endfunction

		// True when the request only makes the core read table entries that were written.
		function bit reads_defined(req_t r);
			logic [MASK_W-1:0] reached;
			case (r.opcode)
				OP_START: reached = closure(r.target_mask);
				OP_STEP: begin
					if ((active & ~rows_written[r.symbol_class]) != '0)
						return 0;
					reached = closure(move_on(active, r.symbol_class));
				end
				default: return 1;
			endcase
			return (reached & ~rows_written[EPS_CLASS]) == '0 && (reached & ~tokens_written) == '0;
		endfunction

		// Apply an accepted request and queue the result it must produce.
		function void note_request(req_t r);
			res_t predicted;
			case (r.opcode)
				OP_WR_TRANS: begin
					next_states[r.state_index][r.symbol_class] = r.target_mask;
					rows_written[r.symbol_class][r.state_index] = 1'b1;
				end
				OP_WR_ACCEPT: begin
					token_of[r.state_index] = r.accept_value;
					tokens_written[r.state_index] = 1'b1;
				end
				OP_START: active = closure(r.target_mask);
				default: active = closure(move_on(active, r.symbol_class));
			endcase
			predicted.active_set = active;
			predicted.token_type = lowest_token(active);
			predicted.set_empty = (active == '0);
			expected_sets.insert(expected_sets.size(), predicted);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_sets.size() == 0) begin
				$error("result with no request outstanding: active_set %h", got.active_set);
				errors++;
				return;
			end
			want = expected_sets.pop_front();
			if (got.active_set !== want.active_set) begin
				$error("active_set: expected %h, got %h", want.active_set, got.active_set);
				errors++;
			end
			if (got.token_type !== want.token_type) begin
				$error("token_type: expected %0d, got %0d", want.token_type, got.token_type);
				errors++;
			end
			if (got.set_empty !== want.set_empty) begin
				$error("set_empty: expected %b, got %b", want.set_empty, got.set_empty);
				errors++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	req_t           req;
	logic           res_valid;
	logic           res_stall;
	res_t           res;
	nfa_set_tracker tracker;
	int             cycles = 0;
	int             burst_left = 0;

	nfa_subset_step_core #(
		.NUM_STATES (N_STATES),
		.NUM_CLASSES(N_CLASSES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_result(res);
	end

	// The receiver stalls with a duty that changes from one stretch to the next.
	initial begin : result_receiver
		int span;
		int stall_pct;
		res_stall = 1'b0;
		forever begin
			span = $urandom_range(10, 150);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			repeat (span) begin
				@(negedge clk);
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	function automatic req_t make_req(op_t op, int st, int cls, logic [MASK_W-1:0] mask, int tok);
		req_t r;
		r.opcode = op;
		r.state_index = st[INDEX_W-1:0];
		r.symbol_class = cls[CLASS_W-1:0];
		r.target_mask = mask;
		r.accept_value = tok[TOKEN_W-1:0];
		return r;
	endfunction

	// Up to max_bits random states; zero bits gives the empty mask.
	function automatic logic [MASK_W-1:0] sparse_mask(int max_bits);
		logic [MASK_W-1:0] m;
		m = '0;
		repeat ($urandom_range(0, max_bits)) m[$urandom_range(0, MASK_W - 1)] = 1'b1;
		return m;
	endfunction

	function automatic logic [MASK_W-1:0] pick_mask();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return sparse_mask(3);
		endcase
	endfunction

	// Send one request; requests go out in bursts with random gaps between them.
	task automatic send_req(input req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		tracker.note_request(r);
	endtask

	initial begin : stimulus
		req_t               r;
		logic [CLASS_W-1:0] work_classes [5];
		int                 tries;
		int                 kind;
		tracker = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		work_classes = '{6'd1, 6'd2, 6'd21, 6'd42, 6'd63};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill the accept types, the epsilon rows and the rows of the working classes.
		for (int s = 0; s < N_STATES; s++)
			send_req(make_req(OP_WR_ACCEPT, s, $urandom, $urandom,
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255)));
		for (int s = 0; s < N_STATES; s++)
			send_req(make_req(OP_WR_TRANS, s, int'(EPS_CLASS), sparse_mask(1), $urandom));
		foreach (work_classes[k])
			for (int s = 0; s < N_STATES; s++)
				send_req(make_req(OP_WR_TRANS, s, int'(work_classes[k]), pick_mask(),
					$urandom));

		// Empty and full starts, then table writes that must leave the full set alone.
		send_req(make_req(OP_START, 0, 0, '0, 0));
		send_req(make_req(OP_START, 31, 63, '1, 255));
		send_req(make_req(OP_WR_TRANS, 1, int'(EPS_CLASS), 32'h4, 0));
		send_req(make_req(OP_WR_TRANS, 2, int'(EPS_CLASS), 32'h2, 0));
		// States 1 and 2 form an epsilon loop; the closure must still end.
		send_req(make_req(OP_START, 0, 0, 32'h2, 0));
		send_req(make_req(OP_WR_ACCEPT, 1, 0, 0, 0));
		send_req(make_req(OP_WR_ACCEPT, 2, 0, 0, 255));
		// A lone state with no epsilon edge and no token reports token zero.
		send_req(make_req(OP_WR_TRANS, 0, int'(EPS_CLASS), '0, 0));
		send_req(make_req(OP_WR_ACCEPT, 0, 0, 0, 0));
		send_req(make_req(OP_START, 0, 0, 32'h1, 0));
		// Fan out from state 0 to every state, then step on the epsilon class.
		send_req(make_req(OP_WR_TRANS, 0, 63, '1, 0));
		send_req(make_req(OP_STEP, 0, 63, '0, 0));
		send_req(make_req(OP_STEP, 0, int'(EPS_CLASS), '0, 0));
		// A step with no targets empties the set, and the empty set stays empty.
		send_req(make_req(OP_START, 0, 0, 32'h1, 0));
		send_req(make_req(OP_WR_TRANS, 0, 62, '0, 0));
		send_req(make_req(OP_STEP, 31, 62, '1, 255));
		send_req(make_req(OP_STEP, 5, 37, '0, 0));
		send_req(make_req(OP_WR_ACCEPT, 31, 0, 0, 255));
		send_req(make_req(OP_START, 0, 0, 32'h8000_0000, 0));

		// Random mix, mostly starts followed by steps on classes with defined rows.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			tries = 0;
			do begin
				r = make_req(OP_STEP, $urandom, $urandom, pick_mask(), $urandom);
				kind = $urandom_range(0, 99);
				if (kind < 15) begin
					r.opcode = OP_WR_TRANS;
					case ($urandom_range(0, 9))
						0: begin
							r.symbol_class = EPS_CLASS;
							r.target_mask = sparse_mask(1);
						end
						1, 2: ;
						default: r.symbol_class = work_classes[$urandom_range(0, 4)];
					endcase
				end else if (kind < 23) begin
					r.opcode = OP_WR_ACCEPT;
					if ($urandom_range(0, 3) == 0)
						r.accept_value = '0;
				end else if (kind < 43) begin
					r.opcode = OP_START;
				end else begin
					case ($urandom_range(0, 7))
						0: r.symbol_class = EPS_CLASS;
						1: ;
						default: r.symbol_class = work_classes[$urandom_range(0, 4)];
					endcase
				end
				tries++;
			end while (!tracker.reads_defined(r) && tries < 8);
			// Table writes never touch undefined entries, so fall back on one.
			if (!tracker.reads_defined(r))
				r.opcode = OP_WR_ACCEPT;
			send_req(r);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (tracker.expected_sets.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
